### hdl/wssm_pkg.sv
// Shared constants and codes for the whitespace-skipping string match block.
`default_nettype none

package wssm_pkg;

   localparam int PAT_CAP    = 16;
   localparam int PAT_IDX_W  = 4;
   localparam int LEN_W      = 5;
   localparam int CHAR_W     = 8;
   localparam int ROW_W      = 16;
   localparam int COL_W      = 12;
   localparam int COUNT_W    = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

   localparam int PATTERN_MAX_DEFAULT = 16;

endpackage

`default_nettype wire

### hdl/wssm_if.sv
// Valid/ready channel interfaces for the text input and the match results.
`default_nettype none

interface wssm_req_if import wssm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_char;
   logic              file_end;

   modport source (output valid, output text_char, output file_end, input ready);
   modport sink   (input valid, input text_char, input file_end, output ready);
endinterface

interface wssm_rsp_if import wssm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               is_total;
   logic [ROW_W-1:0]   match_row;
   logic [COL_W-1:0]   match_col;
   logic [COUNT_W-1:0] match_count;

   modport source (output valid, output is_total, output match_row, output match_col,
                   output match_count, input ready);
   modport sink   (input valid, input is_total, input match_row, input match_col,
                   input match_count, output ready);
endinterface

`default_nettype wire

### hdl/whitespace_skipping_string_match_top.sv
// Whitespace-skipping string matcher: window of non-blank characters compared to a pattern.
//
//   channel  direction  handshake     payload
//   req_ch   in         valid/ready   text_char, file_end
//   rsp_ch   out        valid/ready   is_total, match_row, match_col, match_count
//   csr_*    in         write enable  csr_index, csr_wdata
//
// One word per cycle is sustained while rsp_ch does not stall; an accepted word is held in the
// input register, and its result is loaded from there into the result register.
// Words that produce no result still pass through the input register in order.
// Reset is synchronous and restores line 1, column 0, an empty window and a zero count.
// A stall on rsp_ch holds the input register; req_ch.ready drops once it holds a word.
`default_nettype none

module whitespace_skipping_string_match_top import wssm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   wssm_req_if.sink               req_ch,
   wssm_rsp_if.source             rsp_ch,
   input  wire                    csr_wr_en,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int FILL_W = $clog2(PATTERN_MAX + 1);

   // Configuration
   logic [LEN_W-1:0]      cfg_len_ff;
   logic [CSR_DATA_W-1:0] pat_lo_ff;
   logic [CSR_DATA_W-1:0] pat_hi_ff;

   // Input register
   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_end_ff;

   // Scan state
   logic [CHAR_W-1:0]  win_char_ff [PATTERN_MAX];
   logic [ROW_W-1:0]   win_row_ff  [PATTERN_MAX];
   logic [COL_W-1:0]   win_col_ff  [PATTERN_MAX];
   logic [CHAR_W-1:0]  win_char_in [PATTERN_MAX];
   logic [ROW_W-1:0]   win_row_in  [PATTERN_MAX];
   logic [COL_W-1:0]   win_col_in  [PATTERN_MAX];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               shift_en;

   // Result register
   logic               out_valid_ff, out_valid_in;
   logic               out_total_ff, out_total_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic               advance;
   logic               work;
   logic [CHAR_W-1:0]  pat_chars [PAT_CAP];
   logic [LEN_W-1:0]   eff_len;
   logic [LEN_W-1:0]   pidx;
   logic [COL_W-1:0]   col_step;
   logic               hit;
   logic [ROW_W-1:0]   sel_row;
   logic [COL_W-1:0]   sel_col;
   logic               is_blank;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign work    = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         pat_chars[k]     = pat_lo_ff[8*k +: 8];
         pat_chars[k + 8] = pat_hi_ff[8*k +: 8];
      end
   end

   assign eff_len = (cfg_len_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : cfg_len_ff;
   assign col_step = (&col_ff) ? col_ff : col_ff + COL_W'(1);
   assign is_blank = (in_char_ff == CHAR_SPACE) || (in_char_ff == CHAR_TAB);

   // Window as it stands after the current character is shifted in.
   always_comb begin
      win_char_in[0] = in_char_ff;
      win_row_in[0]  = row_ff;
      win_col_in[0]  = col_step;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         win_char_in[i] = win_char_ff[i-1];
         win_row_in[i]  = win_row_ff[i-1];
         win_col_in[i]  = win_col_ff[i-1];
      end
   end

   assign fill_in = (fill_ff < FILL_W'(PATTERN_MAX)) ? fill_ff + FILL_W'(1) : fill_ff;

   // Window entry i lines up with pattern character eff_len-1-i.
   always_comb begin
      hit     = (eff_len != '0) && (LEN_W'(fill_in) >= eff_len);
      sel_row = '0;
      sel_col = '0;
      pidx    = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (LEN_W'(i) < eff_len) begin
            pidx = eff_len - LEN_W'(i) - LEN_W'(1);
            if (win_char_in[i] != pat_chars[pidx[PAT_IDX_W-1:0]]) begin
               hit = 1'b0;
            end
         end
         if (LEN_W'(i) == eff_len - LEN_W'(1)) begin
            sel_row = win_row_in[i];
            sel_col = win_col_in[i];
         end
      end
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      count_in     = count_ff;
      shift_en     = 1'b0;
      out_valid_in = advance ? 1'b0 : out_valid_ff;
      out_total_in = out_total_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_count_in = out_count_ff;
      if (work) begin
         if (in_end_ff) begin
            out_valid_in = 1'b1;
            out_total_in = 1'b1;
            out_row_in   = '0;
            out_col_in   = '0;
            out_count_in = count_ff;
            row_in       = ROW_W'(1);
            col_in       = '0;
            count_in     = '0;
         end else if (in_char_ff == CHAR_NEWLINE) begin
            row_in = (&row_ff) ? row_ff : row_ff + ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_step;
            if (!is_blank) begin
               shift_en = 1'b1;
               if (hit) begin
                  count_in     = (&count_ff) ? count_ff : count_ff + COUNT_W'(1);
                  out_valid_in = 1'b1;
                  out_total_in = 1'b0;
                  out_row_in   = sel_row;
                  out_col_in   = sel_col;
                  out_count_in = (&count_ff) ? count_ff : count_ff + COUNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff <= LEN_W'(1);
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PATTERN_LENGTH: cfg_len_ff <= csr_wdata[LEN_W-1:0];
            REG_PATTERN_LOW:    pat_lo_ff  <= csr_wdata;
            REG_PATTERN_HIGH:   pat_hi_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_char_ff <= req_ch.text_char;
         in_end_ff  <= req_ch.file_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         row_ff       <= ROW_W'(1);
         col_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (work && in_end_ff) begin
            fill_ff <= '0;
         end else if (shift_en) begin
            fill_ff <= fill_in;
         end
      end
      out_total_ff <= out_total_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_count_ff <= out_count_in;
      if (shift_en) begin
         win_char_ff <= win_char_in;
         win_row_ff  <= win_row_in;
         win_col_ff  <= win_col_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.is_total    = out_total_ff;
   assign rsp_ch.match_row   = out_row_ff;
   assign rsp_ch.match_col   = out_col_ff;
   assign rsp_ch.match_count = out_count_ff;

`ifndef SYNTH
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(PATTERN_MAX))
      else $error("window fill exceeds its depth");

   a_total_clears: assert property (@(posedge clock) disable iff (reset)
      (work && in_end_ff) |=> (count_ff == '0 && fill_ff == '0 && row_ff == ROW_W'(1)))
      else $error("file end did not clear the scan state");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_total_ff) |-> (out_count_ff != '0 && out_row_ff != '0))
      else $error("match report with zero count or zero line");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled without a pending word");
`endif

endmodule

`default_nettype wire

### tb/wssm_match_checker.sv
// Checker for the string matcher: predicts match reports and compares them as they leave.
`timescale 1ns / 100ps

module wssm_match_checker import wssm_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   wssm_req_if                  req_ch,
   wssm_rsp_if                  rsp_ch,
   input  wire                  csr_wr_en,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata,
   output int                   mismatches,
   output int                   reports_pending
);

   typedef struct packed {
      logic               is_total;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [COUNT_W-1:0] count;
   } report_type;

   report_type expected_reports[$];

   logic [CHAR_W-1:0]     win_char [PAT_CAP];
   logic [ROW_W-1:0]      win_row  [PAT_CAP];
   logic [COL_W-1:0]      win_col  [PAT_CAP];
   int                    win_fill;
   logic [ROW_W-1:0]      cur_row;
   logic [COL_W-1:0]      cur_col;
   logic [COUNT_W-1:0]    match_total;
   logic [LEN_W-1:0]      pat_len;
   logic [CSR_DATA_W-1:0] pat_lo;
   logic [CSR_DATA_W-1:0] pat_hi;

   function automatic void restart_file();
      for (int i = 0; i < PAT_CAP; i++) begin
         win_char[i] = '0;
         win_row[i]  = '0;
         win_col[i]  = '0;
      end
      win_fill    = 0;
      cur_row     = 1;
      cur_col     = '0;
      match_total = '0;
   endfunction

   function automatic void scan_word(input logic [CHAR_W-1:0] ch, input logic fe);
      int                span;
      bit                hit;
      logic [CHAR_W-1:0] want_char;
      if (fe) begin
         expected_reports.push_back(report_type'{1'b1, '0, '0, match_total});
         restart_file();
      end else if (ch == CHAR_NEWLINE) begin
         if (cur_row != '1) cur_row++;
         cur_col = '0;
      end else begin
         if (cur_col != '1) cur_col++;
         // Blanks move the column but never enter the window.
         if (ch != CHAR_SPACE && ch != CHAR_TAB) begin
            for (int i = PAT_CAP - 1; i > 0; i--) begin
               win_char[i] = win_char[i-1];
               win_row[i]  = win_row[i-1];
               win_col[i]  = win_col[i-1];
            end
            win_char[0] = ch;
            win_row[0]  = cur_row;
            win_col[0]  = cur_col;
            if (win_fill < PAT_CAP) win_fill++;
            span = (pat_len > PAT_CAP) ? PAT_CAP : int'(pat_len);
            hit  = (span != 0) && (win_fill >= span);
            // The oldest entry of the span lines up with pattern character 0.
            for (int k = 0; k < PAT_CAP; k++) begin
               if (k < span) begin
                  want_char = (k < 8) ? pat_lo[(k % 8) * 8 +: 8] : pat_hi[(k % 8) * 8 +: 8];
                  if (win_char[span-1-k] != want_char) hit = 1'b0;
               end
            end
            if (hit) begin
               if (match_total != '1) match_total++;
               expected_reports.push_back(report_type'{1'b0, win_row[span-1],
                                                       win_col[span-1], match_total});
            end
         end
      end
   endfunction

   task automatic flag(input string field, input longint want, input longint got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         restart_file();
         pat_len    = 1;
         pat_lo     = '0;
         pat_hi     = '0;
         mismatches = 0;
         expected_reports.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_reports.size() == 0) begin
               $display({"%0t ns: result word with none expected, ",
                         "actual total=%0b row=%0d col=%0d count=%0d"},
                        $time, rsp_ch.is_total, rsp_ch.match_row, rsp_ch.match_col,
                        rsp_ch.match_count);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_ch.is_total !== want.is_total)
                  flag("is_total", want.is_total, rsp_ch.is_total);
               if (rsp_ch.match_row !== want.row)
                  flag("match_row", want.row, rsp_ch.match_row);
               if (rsp_ch.match_col !== want.col)
                  flag("match_col", want.col, rsp_ch.match_col);
               if (rsp_ch.match_count !== want.count)
                  flag("match_count", want.count, rsp_ch.match_count);
            end
         end
         if (req_ch.valid && req_ch.ready)
            scan_word(req_ch.text_char, req_ch.file_end);
         if (csr_wr_en) begin
            case (csr_index)
               REG_PATTERN_LENGTH: pat_len = csr_wdata[LEN_W-1:0];
               REG_PATTERN_LOW:    pat_lo  = csr_wdata;
               REG_PATTERN_HIGH:   pat_hi  = csr_wdata;
               default: ;
            endcase
         end
      end
      reports_pending = expected_reports.size();
   end

endmodule

### tb/tb.sv
// Testbench top for the string matcher: clock, reset, text stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module tb;
   import wssm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_WORDS = 1400;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    reports_pending;
   int                    cycle_count = 0;
   int                    words_sent;
   bit                    burst;
   logic [CHAR_W-1:0]     pat [PAT_CAP];

   wssm_req_if req_ch ();
   wssm_rsp_if rsp_ch ();

   whitespace_skipping_string_match_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wssm_match_checker match_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (fail_count),
      .reports_pending (reports_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: stall a random number of cycles before taking each word, none in burst mode.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = burst ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   function automatic logic [CHAR_W-1:0] blank_char();
      case ($urandom_range(0, 2))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         default: return CHAR_NEWLINE;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] solid_char();
      logic [CHAR_W-1:0] ch;
      do ch = CHAR_W'($urandom_range(0, 255));
      while (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_NEWLINE);
      return ch;
   endfunction

   // A small alphabet makes repeats, and so overlapping matches, common.
   function automatic logic [CHAR_W-1:0] pattern_char();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return blank_char();
      if (r < 10) return 8'h61 + CHAR_W'($urandom_range(0, 1));
      return solid_char();
   endfunction

   function automatic logic [CHAR_W-1:0] noise_char();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return blank_char();
      if (r < 3)  return pat[PAT_IDX_W'($urandom_range(0, PAT_CAP - 1))];
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   task automatic send_word(input logic [CHAR_W-1:0] ch, input logic fe);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.text_char <= ch;
      req_ch.file_end  <= fe;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
   endtask

   // Let every result arrive and the pipeline empty before touching the registers.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic load_pattern(input logic [LEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      for (int k = 0; k < 8; k++) begin
         lo[k*8 +: 8] = pat[k];
         hi[k*8 +: 8] = pat[k+8];
      end
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= REG_PATTERN_LENGTH;
      csr_wdata <= CSR_DATA_W'(len);
      @(negedge clock);
      csr_index <= REG_PATTERN_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= REG_PATTERN_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly whole occurrences of the pattern with blanks sprinkled in, some cut
   // short, the rest noise.
   task automatic random_file(input int span);
      int r;
      int cut;
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(0, 9);
         if (span != 0 && r < 6) begin
            cut = (r == 5) ? $urandom_range(0, span - 1) : span;
            for (int k = 0; k < cut; k++) begin
               send_word(pat[k], 1'b0);
               if ($urandom_range(0, 3) == 0) send_word(blank_char(), 1'b0);
            end
         end else begin
            repeat ($urandom_range(1, 4)) send_word(noise_char(), 1'b0);
         end
      end
      send_end();
   endtask

   initial begin
      int               phase;
      int               start;
      int               r;
      int               mode;
      logic [LEN_W-1:0] len;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.text_char = '0;
      req_ch.file_end  = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = REG_PATTERN_LENGTH;
      csr_wdata        = '0;
      words_sent       = 0;
      burst            = 1'b0;
      for (int k = 0; k < PAT_CAP; k++) pat[k] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // After reset the pattern is a single NUL, so NUL bytes match.
      send_word(8'h00, 1'b0);
      send_text("a \t");
      send_word(8'h00, 1'b0);
      send_word(CHAR_NEWLINE, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_end();
      send_end();

      // Overlapping matches across a blank and a line end.
      pat[0] = 8'h61;
      pat[1] = 8'h62;
      pat[2] = 8'h61;
      load_pattern(3);
      send_text("ab a\nba");
      send_end();

      // Zero length never matches.
      load_pattern(0);
      send_word(8'h61, 1'b0);
      send_end();

      phase = 0;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         case (phase)
            0:       len = 0;
            1:       len = 31;
            2:       len = 16;
            3:       len = 17;
            default: begin
               r = $urandom_range(0, 9);
               if (r == 0)     len = 0;
               else if (r == 1) len = LEN_W'($urandom_range(17, 31));
               else if (r < 6)  len = LEN_W'($urandom_range(1, 3));
               else             len = LEN_W'($urandom_range(1, 16));
            end
         endcase
         mode = $urandom_range(0, 7);
         for (int k = 0; k < PAT_CAP; k++) begin
            case (mode)
               0:       pat[k] = 8'h00;
               1:       pat[k] = 8'hFF;
               default: pat[k] = pattern_char();
            endcase
         end
         load_pattern(len);
         burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) random_file((len > PAT_CAP) ? PAT_CAP : int'(len));
         phase++;
      end

      drain();
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
